>>> sv/apt_pkg.sv
// ----------------------------------------------------------------------------
// apt_pkg
// Shared types and constants for the affine point transform block.
// ----------------------------------------------------------------------------
package apt_pkg;

  // binary32 pattern
  typedef logic [31:0] fp32_t;

  // canonical quiet nan, delivered for every nan result
  localparam fp32_t CANON_NAN = 32'h7FC0_0000;
  // negative zero, the exact additive identity
  localparam fp32_t NEG_ZERO  = 32'h8000_0000;

  // register indexes
  localparam logic [2:0] REG_XX_XY     = 3'd0;
  localparam logic [2:0] REG_XZ_YX     = 3'd1;
  localparam logic [2:0] REG_YY_YZ     = 3'd2;
  localparam logic [2:0] REG_ZX_ZY     = 3'd3;
  localparam logic [2:0] REG_ZZ_POSX   = 3'd4;
  localparam logic [2:0] REG_POSY_POSZ = 3'd5;
  localparam logic [2:0] REG_ADD_TRANS = 3'd6;

  // input point request
  typedef struct packed {
    fp32_t in_x;
    fp32_t in_y;
    fp32_t in_z;
    logic  last_in;
  } point_t;

  // transformed point
  typedef struct packed {
    fp32_t out_x;
    fp32_t out_y;
    fp32_t out_z;
    logic  last_out;
  } result_t;

endpackage

>>> sv/apt_fmul.sv
// ----------------------------------------------------------------------------
// apt_fmul
// Three-stage binary32 multiplier, round to nearest even, subnormals kept.
// ----------------------------------------------------------------------------
module apt_fmul (
  input  logic           clk,
  input  apt_pkg::fp32_t a,
  input  apt_pkg::fp32_t b,
  output apt_pkg::fp32_t y
);

  // stage 1 registers
  logic [47:0] s1_prod;
  logic [9:0]  s1_esum;
  logic        s1_sign;
  logic        s1_nan;
  logic        s1_inf;

  // stage 2 registers
  logic [47:0] s2_norm;
  logic [10:0] s2_exp;
  logic        s2_sign;
  logic        s2_nan;
  logic        s2_inf;
  logic        s2_zero;

  // unpack and multiply significands
  always_ff @(posedge clk) begin
    logic a_nan, b_nan, a_inf, b_inf, a_zero, b_zero;
    a_nan  = (a[30:23] == 8'hFF) && (a[22:0] != 23'd0);
    b_nan  = (b[30:23] == 8'hFF) && (b[22:0] != 23'd0);
    a_inf  = (a[30:23] == 8'hFF) && (a[22:0] == 23'd0);
    b_inf  = (b[30:23] == 8'hFF) && (b[22:0] == 23'd0);
    a_zero = (a[30:0] == 31'd0);
    b_zero = (b[30:0] == 31'd0);
    s1_prod <= {(a[30:23] != 8'd0), a[22:0]} * {(b[30:23] != 8'd0), b[22:0]};
    s1_esum <= {2'b00, ((a[30:23] == 8'd0) ? 8'd1 : a[30:23])}
             + {2'b00, ((b[30:23] == 8'd0) ? 8'd1 : b[30:23])};
    s1_sign <= a[31] ^ b[31];
    s1_nan  <= a_nan | b_nan | (a_inf & b_zero) | (b_inf & a_zero);
    s1_inf  <= a_inf | b_inf;
  end

  // leading zero count and left normalize
  always_ff @(posedge clk) begin
    logic [5:0] lz;
    lz = 6'd0;
    for (int i = 0; i < 48; i++) begin
      if (s1_prod[i]) lz = 6'(47 - i);
    end
    s2_norm <= s1_prod << lz;
    s2_exp  <= 11'(s1_esum) - 11'd126 - 11'(lz);
    s2_sign <= s1_sign;
    s2_nan  <= s1_nan;
    s2_inf  <= s1_inf;
    s2_zero <= (s1_prod == 48'd0);
  end

  // subnormal alignment, rounding and packing
  always_ff @(posedge clk) begin
    logic [10:0] sh_full;
    logic [5:0]  sh;
    logic [96:0] wide;
    logic [47:0] kept;
    logic        st;
    logic [7:0]  efield;
    logic        up;
    logic [30:0] mag;
    if ($signed(s2_exp) < 11'sd1) begin
      sh_full = 11'd1 - s2_exp;
      sh      = (sh_full > 11'd49) ? 6'd49 : sh_full[5:0];
      wide    = {s2_norm, 49'd0} >> sh;
      kept    = wide[96:49];
      st      = |wide[48:0];
      efield  = 8'd0;
    end else begin
      kept   = s2_norm;
      st     = 1'b0;
      efield = s2_exp[7:0];
    end
    up  = kept[23] & (st | (|kept[22:0]) | kept[24]);
    mag = {efield, kept[46:24]} + 31'(up);
    if (s2_nan) begin
      y <= apt_pkg::CANON_NAN;
    end else if (s2_inf || (!s2_zero && $signed(s2_exp) > 11'sd254)) begin
      y <= {s2_sign, 8'hFF, 23'd0};
    end else if (s2_zero) begin
      y <= {s2_sign, 31'd0};
    end else begin
      y <= {s2_sign, mag};
    end
  end

endmodule

>>> sv/apt_fadd.sv
// ----------------------------------------------------------------------------
// apt_fadd
// Three-stage binary32 adder, round to nearest even, subnormals kept.
// ----------------------------------------------------------------------------
module apt_fadd (
  input  logic           clk,
  input  apt_pkg::fp32_t a,
  input  apt_pkg::fp32_t b,
  output apt_pkg::fp32_t y
);

  // stage 1 registers
  logic [26:0] s1_big;
  logic [26:0] s1_small;
  logic [7:0]  s1_exp;
  logic        s1_sub;
  logic        s1_sign;
  logic        s1_zsign;
  logic        s1_nan;
  logic        s1_inf;
  logic        s1_isign;

  // stage 2 registers
  logic [27:0] s2_sum;
  logic [4:0]  s2_lz;
  logic [7:0]  s2_exp;
  logic        s2_sign;
  logic        s2_zsign;
  logic        s2_nan;
  logic        s2_inf;
  logic        s2_isign;

  // unpack, order by magnitude, align the smaller operand
  always_ff @(posedge clk) begin
    logic        a_nan, b_nan, a_inf, b_inf, swap;
    apt_pkg::fp32_t big, small_op;
    logic [7:0]  e_big, e_small, diff;
    logic [4:0]  d;
    logic [53:0] wide;
    a_nan    = (a[30:23] == 8'hFF) && (a[22:0] != 23'd0);
    b_nan    = (b[30:23] == 8'hFF) && (b[22:0] != 23'd0);
    a_inf    = (a[30:23] == 8'hFF) && (a[22:0] == 23'd0);
    b_inf    = (b[30:23] == 8'hFF) && (b[22:0] == 23'd0);
    swap     = (b[30:0] > a[30:0]);
    big      = swap ? b : a;
    small_op = swap ? a : b;
    e_big    = (big[30:23] == 8'd0) ? 8'd1 : big[30:23];
    e_small  = (small_op[30:23] == 8'd0) ? 8'd1 : small_op[30:23];
    diff     = e_big - e_small;
    d        = (diff > 8'd31) ? 5'd31 : diff[4:0];
    wide     = {(small_op[30:23] != 8'd0), small_op[22:0], 3'b000, 27'd0} >> d;
    s1_big   <= {(big[30:23] != 8'd0), big[22:0], 3'b000};
    s1_small <= {wide[53:28], wide[27] | (|wide[26:0])};
    s1_exp   <= e_big;
    s1_sub   <= big[31] ^ small_op[31];
    s1_sign  <= big[31];
    s1_zsign <= a[31] & b[31];
    s1_nan   <= a_nan | b_nan | (a_inf & b_inf & (a[31] != b[31]));
    s1_inf   <= a_inf | b_inf;
    s1_isign <= a_inf ? a[31] : b[31];
  end

  // add or subtract, count leading zeros
  always_ff @(posedge clk) begin
    logic [27:0] sum;
    logic [4:0]  lz;
    sum = s1_sub ? ({1'b0, s1_big} - {1'b0, s1_small})
                 : ({1'b0, s1_big} + {1'b0, s1_small});
    lz  = 5'd0;
    for (int i = 0; i < 27; i++) begin
      if (sum[i]) lz = 5'(26 - i);
    end
    s2_sum   <= sum;
    s2_lz    <= lz;
    s2_exp   <= s1_exp;
    s2_sign  <= s1_sign;
    s2_zsign <= s1_zsign;
    s2_nan   <= s1_nan;
    s2_inf   <= s1_inf;
    s2_isign <= s1_isign;
  end

  // normalize, round and pack
  always_ff @(posedge clk) begin
    logic [26:0] norm;
    logic [8:0]  e;
    logic [7:0]  sh;
    logic [7:0]  efield;
    logic        up;
    logic [30:0] mag;
    if (s2_sum[27]) begin
      norm = {s2_sum[27:2], s2_sum[1] | s2_sum[0]};
      e    = {1'b0, s2_exp} + 9'd1;
    end else begin
      sh   = ({3'b000, s2_lz} < (s2_exp - 8'd1)) ? {3'b000, s2_lz} : (s2_exp - 8'd1);
      norm = s2_sum[26:0] << sh;
      e    = {1'b0, s2_exp - sh};
    end
    efield = norm[26] ? e[7:0] : 8'd0;
    up     = norm[2] & ((|norm[1:0]) | norm[3]);
    mag    = {efield, norm[25:3]} + 31'(up);
    if (s2_nan) begin
      y <= apt_pkg::CANON_NAN;
    end else if (s2_inf) begin
      y <= {s2_isign, 8'hFF, 23'd0};
    end else if (s2_sum == 28'd0) begin
      y <= {s2_zsign, 31'd0};
    end else if (e > 9'd254) begin
      y <= {s2_sign, 8'hFF, 23'd0};
    end else begin
      y <= {s2_sign, mag};
    end
  end

endmodule

>>> sv/affine_point_transform.sv
// ----------------------------------------------------------------------------
// affine_point_transform
// Applies a 3x4 affine matrix to a stream of binary32 points.
// ----------------------------------------------------------------------------
// datapath: accepted request to done passes through the multiply, then three adds in series
// throughput: one point per cycle; busy is always low, every stage advances each cycle
// each fp unit is three register stages; the add chain per component sets the latency
// reset: synchronous, clears the valid pipeline, matrix to zero, add_translation to one
// results are strobed on done for one cycle; the receiver cannot stall
module affine_point_transform (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  apt_pkg::point_t   point,
  output logic              done,
  output apt_pkg::result_t  result,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [5:0]        paddr,
  input  logic [63:0]       pwdata,
  output logic [63:0]       prdata,
  output logic              pready
);

  localparam int LAT = 12;

  logic [63:0] mat_xx_xy, mat_xz_yx, mat_yy_yz, mat_zx_zy, mat_zz_posx, mat_posy_posz;
  logic        add_translation;
  logic [2:0]  reg_idx;

  // register file
  assign reg_idx = paddr[5:3];
  assign pready  = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      mat_xx_xy       <= '0;
      mat_xz_yx       <= '0;
      mat_yy_yz       <= '0;
      mat_zx_zy       <= '0;
      mat_zz_posx     <= '0;
      mat_posy_posz   <= '0;
      add_translation <= 1'b1;
    end else if (psel && penable && pwrite) begin
      unique case (reg_idx)
        apt_pkg::REG_XX_XY:     mat_xx_xy       <= pwdata;
        apt_pkg::REG_XZ_YX:     mat_xz_yx       <= pwdata;
        apt_pkg::REG_YY_YZ:     mat_yy_yz       <= pwdata;
        apt_pkg::REG_ZX_ZY:     mat_zx_zy       <= pwdata;
        apt_pkg::REG_ZZ_POSX:   mat_zz_posx     <= pwdata;
        apt_pkg::REG_POSY_POSZ: mat_posy_posz   <= pwdata;
        apt_pkg::REG_ADD_TRANS: add_translation <= pwdata[0];
        default: ;
      endcase
    end
  end

  // register read
  always_comb begin
    unique case (reg_idx)
      apt_pkg::REG_XX_XY:     prdata = mat_xx_xy;
      apt_pkg::REG_XZ_YX:     prdata = mat_xz_yx;
      apt_pkg::REG_YY_YZ:     prdata = mat_yy_yz;
      apt_pkg::REG_ZX_ZY:     prdata = mat_zx_zy;
      apt_pkg::REG_ZZ_POSX:   prdata = mat_zz_posx;
      apt_pkg::REG_POSY_POSZ: prdata = mat_posy_posz;
      apt_pkg::REG_ADD_TRANS: prdata = {63'd0, add_translation};
      default:                prdata = '0;
    endcase
  end

  // matrix columns per output component
  apt_pkg::fp32_t mx [3];
  apt_pkg::fp32_t my [3];
  apt_pkg::fp32_t mz [3];
  apt_pkg::fp32_t pos [3];
  apt_pkg::fp32_t res [3];

  assign mx[0]  = mat_xx_xy[31:0];
  assign mx[1]  = mat_xx_xy[63:32];
  assign mx[2]  = mat_xz_yx[31:0];
  assign my[0]  = mat_xz_yx[63:32];
  assign my[1]  = mat_yy_yz[31:0];
  assign my[2]  = mat_yy_yz[63:32];
  assign mz[0]  = mat_zx_zy[31:0];
  assign mz[1]  = mat_zx_zy[63:32];
  assign mz[2]  = mat_zz_posx[31:0];
  assign pos[0] = mat_zz_posx[63:32];
  assign pos[1] = mat_posy_posz[31:0];
  assign pos[2] = mat_posy_posz[63:32];

  // per component datapath: three products, then a left to right add chain
  for (genvar c = 0; c < 3; c++) begin : g_comp
    apt_pkg::fp32_t px, py, pz, s1, s2, term;
    apt_pkg::fp32_t pz_d [3];

    apt_fmul u_mx (.clk(clk), .a(point.in_x), .b(mx[c]), .y(px));
    apt_fmul u_my (.clk(clk), .a(point.in_y), .b(my[c]), .y(py));
    apt_fmul u_mz (.clk(clk), .a(point.in_z), .b(mz[c]), .y(pz));

    // hold z product while the first add runs
    always_ff @(posedge clk) begin
      pz_d[0] <= pz;
      pz_d[1] <= pz_d[0];
      pz_d[2] <= pz_d[1];
    end

    // adding negative zero leaves the sum unchanged for normals
    assign term = add_translation ? pos[c] : apt_pkg::NEG_ZERO;

    apt_fadd u_a1 (.clk(clk), .a(px), .b(py),      .y(s1));
    apt_fadd u_a2 (.clk(clk), .a(s1), .b(pz_d[2]), .y(s2));
    apt_fadd u_a3 (.clk(clk), .a(s2), .b(term),    .y(res[c]));
  end

  // valid and last flag travel alongside the datapath
  logic [LAT-1:0] vld;
  logic [LAT-1:0] last_d;
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[LAT-2:0], start && !busy};
    end
    last_d <= {last_d[LAT-2:0], point.last_in};
  end

  assign busy            = 1'b0;
  assign done            = vld[LAT-1];
  assign result.out_x    = res[0];
  assign result.out_y    = res[1];
  assign result.out_z    = res[2];
  assign result.last_out = last_d[LAT-1];

`ifndef NO_ASSERTIONS
  // every accepted request produces a result after the fixed latency
  a_latency: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##12 done)
    else $error("request did not complete after pipeline latency");

  // a result appears only for a request accepted earlier
  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, 12))
    else $error("result without matching request");

  // pipeline is empty right after reset
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !done)
    else $error("result strobe right after reset");
`endif

endmodule
